// ----- design/uart_bq_pkg.sv -----
// ----------------------------------------------------------------------------
// uart_bq_pkg
// Shared constants, codes and ring-unit types for the buffered UART queues.
// ----------------------------------------------------------------------------
package uart_bq_pkg;

    // Ring geometry and drain batch
    localparam int RING_DEPTH  = 1024;
    localparam int DRAIN_BATCH = 16;
    localparam int PTR_W       = $clog2(RING_DEPTH);
    localparam int LVL_W       = $clog2(RING_DEPTH + 1);
    localparam int CNT_W       = $clog2(DRAIN_BATCH + 1);

    // Fixed field widths
    localparam int FILL_W = 11;
    localparam int KIND_W = 3;

    // Request opcodes
    localparam logic [1:0] OP_PUT  = 2'd0;
    localparam logic [1:0] OP_GET  = 2'd1;
    localparam logic [1:0] OP_INT  = 2'd2;
    localparam logic [1:0] OP_RXB  = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_PUT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GET  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TXW  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DONE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RX   = 3'd4;

    // Interrupt identification codes that start a transmit drain
    localparam logic [3:0] IIR_THR_EMPTY = 4'h2;
    localparam logic [3:0] IIR_THR_ALT   = 4'h7;

    // Interrupt identification codes that only acknowledge
    localparam logic [3:0] IIR_RX_DATA    = 4'h4;
    localparam logic [3:0] IIR_RX_TIMEOUT = 4'hC;

    // Characters
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Request into the shared ring pointer unit
    typedef struct packed {
        logic [PTR_W-1:0] wptr;
        logic [PTR_W-1:0] rptr;
        logic [LVL_W-1:0] level;
        logic             push;
        logic             pop;
    } ring_req_t;

    // Response from the shared ring pointer unit
    typedef struct packed {
        logic [PTR_W-1:0] wptr;
        logic [PTR_W-1:0] rptr;
        logic [LVL_W-1:0] level;
        logic             full;
        logic             empty;
    } ring_rsp_t;

endpackage

// ----- design/uart_bq_ram.sv -----
// ----------------------------------------------------------------------------
// uart_bq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module uart_bq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/uart_bq_ring_unit.sv -----
// ----------------------------------------------------------------------------
// uart_bq_ring_unit
// Shared ring pointer unit: advances one pointer and steps the level.
// ----------------------------------------------------------------------------
module uart_bq_ring_unit (
    input  uart_bq_pkg::ring_req_t req,
    output uart_bq_pkg::ring_rsp_t rsp
);

    logic [uart_bq_pkg::PTR_W-1:0] wptr_inc;
    logic [uart_bq_pkg::PTR_W-1:0] rptr_inc;

    // Wrapping increments
    always_comb begin
        if (req.wptr == uart_bq_pkg::PTR_W'(uart_bq_pkg::RING_DEPTH - 1)) begin
            wptr_inc = '0;
        end else begin
            wptr_inc = req.wptr + 1'b1;
        end
        if (req.rptr == uart_bq_pkg::PTR_W'(uart_bq_pkg::RING_DEPTH - 1)) begin
            rptr_inc = '0;
        end else begin
            rptr_inc = req.rptr + 1'b1;
        end
    end

    // Status and next pointers
    always_comb begin
        rsp.full  = (req.level == uart_bq_pkg::LVL_W'(uart_bq_pkg::RING_DEPTH));
        rsp.empty = (req.level == '0);
        rsp.wptr  = req.wptr;
        rsp.rptr  = req.rptr;
        rsp.level = req.level;
        if (req.push) begin
            rsp.wptr  = wptr_inc;
            rsp.level = req.level + 1'b1;
        end else if (req.pop) begin
            rsp.rptr  = rptr_inc;
            rsp.level = req.level - 1'b1;
        end
    end

endmodule

// ----- design/uart_bq_core_top.sv -----
// ----------------------------------------------------------------------------
// uart_buffered_tx_rx_queues_core
// Buffered UART transmit and receive rings with newline expansion.
// ----------------------------------------------------------------------------
// Each request is accepted in the idle state and passes through the execute
// state, in which the sequencer drives the single shared ring pointer unit
// and the ring RAM ports, and the output state, which loads the result
// register once it is free. A put of newline that queues the carriage return
// repeats the execute state. A transmit drain of n bytes (up to DRAIN_BATCH)
// passes through the drain and output states for each byte, paced by the
// registered RAM read. A result that waits on m_ready stalls
// the sequencer; the next request is accepted while the last result still
// waits. Both rings need no clearing after reset. The enable register is
// written through cfg_valid/cfg_data at any time and is always ready.
// ----------------------------------------------------------------------------
module uart_buffered_tx_rx_queues_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // Request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_data_byte,
    input  logic [3:0]  s_iir_code,
    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_out_byte,
    output logic        m_ok,
    output logic        m_tx_irq_enable,
    output logic        m_last,
    output logic [10:0] m_tx_fill,
    output logic [10:0] m_rx_fill
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Control state
    logic                          en_reg;
    logic                          tx_int_reg, tx_int_next;
    logic [uart_bq_pkg::PTR_W-1:0] tx_wptr_reg, tx_wptr_next;
    logic [uart_bq_pkg::PTR_W-1:0] tx_rptr_reg, tx_rptr_next;
    logic [uart_bq_pkg::LVL_W-1:0] tx_level_reg, tx_level_next;
    logic [uart_bq_pkg::PTR_W-1:0] rx_wptr_reg, rx_wptr_next;
    logic [uart_bq_pkg::PTR_W-1:0] rx_rptr_reg, rx_rptr_next;
    logic [uart_bq_pkg::LVL_W-1:0] rx_level_reg, rx_level_next;
    logic [uart_bq_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                          cr_done_reg, cr_done_next;
    logic                          m_valid_reg, m_valid_next;

    // Latched request
    logic [1:0] op_reg;
    logic [7:0] data_reg;
    logic [3:0] code_reg;

    // Pending result
    logic [uart_bq_pkg::KIND_W-1:0] res_kind_reg, res_kind_next;
    logic                           res_ok_reg, res_ok_next;
    logic                           res_last_reg, res_last_next;
    logic                           res_rx_reg, res_rx_next;
    logic                           res_tx_reg, res_tx_next;

    // Result register payload
    logic [uart_bq_pkg::KIND_W-1:0]  m_kind_reg;
    logic [7:0]                      m_byte_reg;
    logic                            m_ok_reg;
    logic                            m_en_reg;
    logic                            m_last_reg;
    logic [uart_bq_pkg::FILL_W-1:0]  m_tx_fill_reg;
    logic [uart_bq_pkg::FILL_W-1:0]  m_rx_fill_reg;

    // Shared unit and RAM controls
    uart_bq_pkg::ring_req_t ring_req;
    uart_bq_pkg::ring_rsp_t ring_rsp;
    logic       sel_rx;
    logic       tx_we, tx_re, rx_we, rx_re;
    logic [7:0] tx_wdata;
    logic [7:0] tx_rdata, rx_rdata;
    logic       out_free;
    logic       accept;
    logic       drain_code;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign drain_code = (code_reg == uart_bq_pkg::IIR_THR_EMPTY) ||
                        (code_reg == uart_bq_pkg::IIR_THR_ALT);

    // Shared ring pointer unit, steered to one ring per cycle
    always_comb begin
        ring_req.wptr  = sel_rx ? rx_wptr_reg  : tx_wptr_reg;
        ring_req.rptr  = sel_rx ? rx_rptr_reg  : tx_rptr_reg;
        ring_req.level = sel_rx ? rx_level_reg : tx_level_reg;
        ring_req.push  = (tx_we || rx_we);
        ring_req.pop   = (tx_re || rx_re);
    end

    uart_bq_ring_unit u_ring_unit (
        .req (ring_req),
        .rsp (ring_rsp)
    );

    uart_bq_ram #(
        .DEPTH (uart_bq_pkg::RING_DEPTH),
        .WIDTH (8)
    ) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_we),
        .waddr (tx_wptr_reg),
        .wdata (tx_wdata),
        .re    (tx_re),
        .raddr (tx_rptr_reg),
        .rdata (tx_rdata)
    );

    uart_bq_ram #(
        .DEPTH (uart_bq_pkg::RING_DEPTH),
        .WIDTH (8)
    ) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_we),
        .waddr (rx_wptr_reg),
        .wdata (data_reg),
        .re    (rx_re),
        .raddr (rx_rptr_reg),
        .rdata (rx_rdata)
    );

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        tx_int_next   = tx_int_reg;
        cnt_next      = cnt_reg;
        cr_done_next  = cr_done_reg;
        res_kind_next = res_kind_reg;
        res_ok_next   = res_ok_reg;
        res_last_next = res_last_reg;
        res_rx_next   = res_rx_reg;
        res_tx_next   = res_tx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        sel_rx        = 1'b0;
        tx_we         = 1'b0;
        tx_re         = 1'b0;
        rx_we         = 1'b0;
        rx_re         = 1'b0;
        tx_wdata      = data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cr_done_next = 1'b0;
                    cnt_next     = '0;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_ok_next   = 1'b0;
                res_last_next = 1'b1;
                res_rx_next   = 1'b0;
                res_tx_next   = 1'b0;
                state_next    = ST_OUT;
                unique case (op_reg)
                    uart_bq_pkg::OP_PUT: begin
                        res_kind_next = uart_bq_pkg::KIND_PUT;
                        if (en_reg) begin
                            if (data_reg == uart_bq_pkg::CH_LF && !cr_done_reg) begin
                                // Carriage return goes in ahead of the newline
                                if (!ring_rsp.full) begin
                                    tx_we        = 1'b1;
                                    tx_wdata     = uart_bq_pkg::CH_CR;
                                    cr_done_next = 1'b1;
                                    tx_int_next  = 1'b1;
                                    state_next   = ST_EXEC;
                                end
                            end else if (!ring_rsp.full) begin
                                tx_we       = 1'b1;
                                tx_int_next = 1'b1;
                                res_ok_next = 1'b1;
                            end
                        end
                    end
                    uart_bq_pkg::OP_GET: begin
                        res_kind_next = uart_bq_pkg::KIND_GET;
                        sel_rx        = 1'b1;
                        if (en_reg && !ring_rsp.empty) begin
                            rx_re       = 1'b1;
                            res_ok_next = 1'b1;
                            res_rx_next = 1'b1;
                        end
                    end
                    uart_bq_pkg::OP_INT: begin
                        res_kind_next = uart_bq_pkg::KIND_DONE;
                        if (drain_code) begin
                            // Ring ends empty exactly when the level fits in one batch
                            if (32'(tx_level_reg) <= 32'(uart_bq_pkg::DRAIN_BATCH)) begin
                                tx_int_next = 1'b0;
                            end
                            if (!ring_rsp.empty) begin
                                state_next = ST_DRAIN;
                            end
                        end
                    end
                    uart_bq_pkg::OP_RXB: begin
                        res_kind_next = uart_bq_pkg::KIND_RX;
                        sel_rx        = 1'b1;
                        if (!ring_rsp.full) begin
                            rx_we       = 1'b1;
                            res_ok_next = 1'b1;
                        end
                    end
                    default: begin
                        res_kind_next = uart_bq_pkg::KIND_DONE;
                    end
                endcase
            end
            ST_DRAIN: begin
                // Pop one byte; its data is ready in the output cycle
                tx_re         = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                res_kind_next = uart_bq_pkg::KIND_TXW;
                res_ok_next   = 1'b1;
                res_rx_next   = 1'b0;
                res_tx_next   = 1'b1;
                res_last_next = (cnt_next == uart_bq_pkg::CNT_W'(uart_bq_pkg::DRAIN_BATCH)) ||
                                (ring_rsp.level == '0);
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = res_last_reg ? ST_IDLE : ST_DRAIN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Ring state follows the shared unit for the selected ring
    always_comb begin
        tx_wptr_next  = tx_wptr_reg;
        tx_rptr_next  = tx_rptr_reg;
        tx_level_next = tx_level_reg;
        rx_wptr_next  = rx_wptr_reg;
        rx_rptr_next  = rx_rptr_reg;
        rx_level_next = rx_level_reg;
        if (sel_rx) begin
            rx_wptr_next  = ring_rsp.wptr;
            rx_rptr_next  = ring_rsp.rptr;
            rx_level_next = ring_rsp.level;
        end else begin
            tx_wptr_next  = ring_rsp.wptr;
            tx_rptr_next  = ring_rsp.rptr;
            tx_level_next = ring_rsp.level;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            en_reg       <= 1'b0;
            tx_int_reg   <= 1'b0;
            tx_wptr_reg  <= '0;
            tx_rptr_reg  <= '0;
            tx_level_reg <= '0;
            rx_wptr_reg  <= '0;
            rx_rptr_reg  <= '0;
            rx_level_reg <= '0;
            cnt_reg      <= '0;
            cr_done_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            res_last_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            tx_int_reg   <= tx_int_next;
            tx_wptr_reg  <= tx_wptr_next;
            tx_rptr_reg  <= tx_rptr_next;
            tx_level_reg <= tx_level_next;
            rx_wptr_reg  <= rx_wptr_next;
            rx_rptr_reg  <= rx_rptr_next;
            rx_level_reg <= rx_level_next;
            cnt_reg      <= cnt_next;
            cr_done_reg  <= cr_done_next;
            m_valid_reg  <= m_valid_next;
            res_last_reg <= res_last_next;
            if (cfg_valid) begin
                en_reg <= cfg_data;
            end
        end
    end

    // Request latch and pending result
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_opcode;
            data_reg <= s_data_byte;
            code_reg <= s_iir_code;
        end
        res_kind_reg <= res_kind_next;
        res_ok_reg   <= res_ok_next;
        res_rx_reg   <= res_rx_next;
        res_tx_reg   <= res_tx_next;
    end

    // Result register load
    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_kind_reg    <= res_kind_reg;
            m_ok_reg      <= res_ok_reg;
            m_last_reg    <= res_last_reg;
            m_en_reg      <= tx_int_reg;
            m_tx_fill_reg <= uart_bq_pkg::FILL_W'(tx_level_reg);
            m_rx_fill_reg <= uart_bq_pkg::FILL_W'(rx_level_reg);
            if (res_rx_reg) begin
                m_byte_reg <= rx_rdata;
            end else if (res_tx_reg) begin
                m_byte_reg <= tx_rdata;
            end else begin
                m_byte_reg <= 8'h00;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_out_byte      = m_byte_reg;
    assign m_ok            = m_ok_reg;
    assign m_tx_irq_enable = m_en_reg;
    assign m_last          = m_last_reg;
    assign m_tx_fill       = m_tx_fill_reg;
    assign m_rx_fill       = m_rx_fill_reg;

`ifndef NO_ASSERTIONS
    // The shared unit never pushes into a full ring
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ring_req.push && ring_rsp.full))
        else $error("push into full ring");

    // Drain never goes past one batch
    a_drain_batch: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> (32'(cnt_reg) < 32'(uart_bq_pkg::DRAIN_BATCH)))
        else $error("drain exceeded batch");

    // Queued transmit bytes always leave the interrupt enabled
    a_tx_int_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && tx_level_reg != '0) |-> tx_int_reg)
        else $error("tx bytes queued with interrupt disabled");

    // An accepted request blocks the next one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request accepted while busy");
`endif

endmodule
